// File: hw/rtl/fresnel_reflectance_unit_defines.svh
// Assertion macros for the Fresnel reflectance unit checker.
// Used only by frsn_chk; no other dependencies.
`ifndef FRESNEL_REFLECTANCE_UNIT_DEFINES_SVH
`define FRESNEL_REFLECTANCE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FRSN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define FRSN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/frsn_pkg.sv
// Shared constants and types for the Fresnel reflectance unit.
// No dependencies.
package frsn_pkg;

  localparam int VEC_FRAC_BITS_DEF = 14;

  localparam int VEC_W   = 16;
  localparam int IDX_W   = 14;
  localparam int C_W     = 31;
  localparam int RAD_W   = 62;
  localparam int SIN_T_W = 30;
  localparam int PROD_W  = 45;
  localparam int DEN_W   = 46;
  localparam int RAT_W   = 19;
  localparam int RATIO_BITS = 18;
  localparam int REFL_W  = 16;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;

  localparam logic [RAD_W-1:0]  ONE_Q60  = 62'd1 << 60;
  localparam logic [IDX_W-1:0]  ETA_ONE  = 14'd4096;
  localparam logic [RAT_W-1:0]  RAT_ONE  = 19'd1 << RATIO_BITS;
  localparam logic [REFL_W-1:0] REFL_ONE = 16'd32768;

  typedef struct packed {
    logic [C_W-1:0]   c;
    logic [IDX_W-1:0] eta_i;
    logic [IDX_W-1:0] eta_t;
    logic             tir;
    logic             zs;
  } frsn_side_t;

endpackage

// File: hw/rtl/frsn_front.sv
// Front end: dot product, clamp, cosine of incidence, index swap, 1 - cos^2.
// Four register stages. Depends on frsn_pkg.
module frsn_front #(
  parameter int VEC_FRAC_BITS = frsn_pkg::VEC_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [frsn_pkg::VEC_W-1:0]   dir_x_i,
  input  logic signed [frsn_pkg::VEC_W-1:0]   dir_y_i,
  input  logic signed [frsn_pkg::VEC_W-1:0]   dir_z_i,
  input  logic signed [frsn_pkg::VEC_W-1:0]   norm_x_i,
  input  logic signed [frsn_pkg::VEC_W-1:0]   norm_y_i,
  input  logic signed [frsn_pkg::VEC_W-1:0]   norm_z_i,
  input  logic        [frsn_pkg::IDX_W-1:0]   material_index_i,
  output logic                                valid_o,
  output logic        [frsn_pkg::RAD_W-1:0]   rad_o,
  output frsn_pkg::frsn_side_t                side_o
);

  localparam int TWO_F = 2 * VEC_FRAC_BITS;
  localparam int SH_R  = (TWO_F >= 30) ? TWO_F - 30 : 0;
  localparam int SH_L  = (TWO_F >= 30) ? 0 : 30 - TWO_F;
  localparam logic [63:0] ONE2F = 64'd1 << TWO_F;

  logic                              v1_q, v2_q, v3_q, v4_q;
  logic signed [2*frsn_pkg::VEC_W-1:0] px_q, py_q, pz_q;
  logic [frsn_pkg::IDX_W-1:0]        idx1_q;
  frsn_pkg::frsn_side_t              side2_q, side3_q, side4_q, side2_d;
  logic [2*frsn_pkg::C_W-1:0]        csq_q;
  logic [frsn_pkg::RAD_W-1:0]        rad_q;

  logic signed [33:0] dot;
  logic        [33:0] mag;
  logic        [63:0] mag_w, magc, c_w;
  logic               leaving;

  always_comb begin
    dot = 34'(px_q) + 34'(py_q) + 34'(pz_q);
    leaving = dot > 34'sd0;
    mag = dot[33] ? 34'(-dot) : 34'(dot);
    mag_w = {30'd0, mag};
    magc = (mag_w > ONE2F) ? ONE2F : mag_w;
    c_w = (magc >> SH_R) << SH_L;
    side2_d.c = c_w[frsn_pkg::C_W-1:0];
    side2_d.eta_i = leaving ? idx1_q : frsn_pkg::ETA_ONE;
    side2_d.eta_t = leaving ? frsn_pkg::ETA_ONE : idx1_q;
    side2_d.tir = (side2_d.eta_t == '0);
    side2_d.zs = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q    <= dir_x_i * norm_x_i;
      py_q    <= dir_y_i * norm_y_i;
      pz_q    <= dir_z_i * norm_z_i;
      idx1_q  <= material_index_i;
      side2_q <= side2_d;
      csq_q   <= side2_q.c * side2_q.c;
      side3_q <= side2_q;
      rad_q   <= frsn_pkg::ONE_Q60 - csq_q;
      side4_q <= side3_q;
    end
  end

  assign valid_o = v4_q;
  assign rad_o   = rad_q;
  assign side_o  = side4_q;

endmodule

// File: hw/rtl/frsn_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Generic; carries a side payload alongside. No package dependency.
module frsn_sqrt #(
  parameter int  IN_W = 62,
  parameter type side_t = logic,
  localparam int OUT_W = IN_W / 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [OUT_W-1:0]  root_o,
  output side_t             side_o
);

  localparam int REM_W = OUT_W + 2;

  logic             v_q    [OUT_W];
  logic [REM_W-1:0] rem_q  [OUT_W];
  logic [OUT_W-1:0] root_q [OUT_W];
  logic [IN_W-1:0]  rad_q  [OUT_W];
  side_t            side_q [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic             v_in;
    logic [REM_W-1:0] rem_in, shifted, trial, rem_d;
    logic [OUT_W-1:0] root_in, root_d;
    logic [IN_W-1:0]  rad_in;
    side_t            side_in;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      shifted = {rem_in[REM_W-3:0], rad_in[IN_W-1 -: 2]};
      trial   = {root_in, 2'b01};
      take    = shifted >= trial;
      rem_d   = take ? shifted - trial : shifted;
      root_d  = {root_in[OUT_W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        rad_q[k]  <= {rad_in[IN_W-3:0], 2'b00};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[OUT_W-1];
  assign root_o  = root_q[OUT_W-1];
  assign side_o  = side_q[OUT_W-1];

endmodule

// File: hw/rtl/frsn_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Divides {rem_i, low_i} by den_i; rem_i must be below den_i. No package use.
module frsn_div #(
  parameter int  DEN_W = 14,
  parameter int  Q_W   = 30,
  parameter type side_t = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [Q_W-1:0]    low_i,
  input  logic [DEN_W-1:0]  den_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output side_t             side_o
);

  logic             v_q    [Q_W];
  logic [DEN_W-1:0] rem_q  [Q_W];
  logic [Q_W-1:0]   low_q  [Q_W];
  logic [DEN_W-1:0] den_q  [Q_W];
  logic [Q_W-1:0]   quo_q  [Q_W];
  side_t            side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             v_in;
    logic [DEN_W-1:0] rem_in, den_in, rem_d;
    logic [Q_W-1:0]   low_in, quo_in;
    logic [DEN_W:0]   r2, diff;
    side_t            side_in;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rem_i;
      assign low_in  = low_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      r2    = {rem_in, low_in[Q_W-1]};
      diff  = r2 - {1'b0, den_in};
      take  = r2 >= {1'b0, den_in};
      rem_d = take ? diff[DEN_W-1:0] : r2[DEN_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= {low_in[Q_W-2:0], 1'b0};
        den_q[k]  <= den_in;
        quo_q[k]  <= {quo_in[Q_W-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// File: hw/rtl/fresnel_reflectance_unit.sv
// Top level of the Fresnel reflectance unit.
// Depends on frsn_pkg, frsn_front, frsn_sqrt and frsn_div.
//
// Usage:
//   Input stream s_axis: one surface hit per request (direction, normal,
//   material index). Output stream m_axis: reflectance in tdata, the total
//   internal reflection flag in tuser.
//   Throughput: one request per cycle, sustained while the skid buffer is empty.
//   Path from input acceptance to m_axis_tvalid: the two 31-stage square
//   roots, the 30-stage index divider and the 19-stage ratio dividers, plus
//   twelve arithmetic stages and the output register.
//   The block holds no state between requests.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls, the pipeline keeps moving until a one-entry
//   skid buffer behind the output register fills; only then does
//   s_axis_tready drop, and the whole pipeline freezes. No request is lost or
//   repeated.
module fresnel_reflectance_unit #(
  parameter int VEC_FRAC_BITS = frsn_pkg::VEC_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, material_index, zero pad
  input  logic [frsn_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // reflectance
  output logic [frsn_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // total_internal
  output logic                                 m_axis_tuser
);

  localparam int C_W   = frsn_pkg::C_W;
  localparam int IDX_W = frsn_pkg::IDX_W;

  logic en;

  // output register and skid entry
  logic                        out_v_q, sk_v_q, pop;
  logic [frsn_pkg::REFL_W-1:0] out_refl_q, sk_refl_q;
  logic                        out_tir_q, sk_tir_q;

  assign en = !sk_v_q;

  // front end
  logic                 f_v;
  logic [frsn_pkg::RAD_W-1:0] f_rad;
  frsn_pkg::frsn_side_t f_side;

  frsn_front #(.VEC_FRAC_BITS(VEC_FRAC_BITS)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i          (s_axis_tvalid && s_axis_tready),
    .dir_x_i          (s_axis_tdata[15:0]),
    .dir_y_i          (s_axis_tdata[31:16]),
    .dir_z_i          (s_axis_tdata[47:32]),
    .norm_x_i         (s_axis_tdata[63:48]),
    .norm_y_i         (s_axis_tdata[79:64]),
    .norm_z_i         (s_axis_tdata[95:80]),
    .material_index_i (s_axis_tdata[109:96]),
    .valid_o          (f_v),
    .rad_o            (f_rad),
    .side_o           (f_side)
  );

  // sin_i
  logic                 si_v;
  logic [C_W-1:0]       sin_i;
  frsn_pkg::frsn_side_t si_side;

  frsn_sqrt #(.IN_W(frsn_pkg::RAD_W), .side_t(frsn_pkg::frsn_side_t)) u_sqrt_sin (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_v), .rad_i(f_rad), .side_i(f_side),
    .valid_o(si_v), .root_o(sin_i), .side_o(si_side)
  );

  // sin_i * eta_i, then overflow test and divider setup
  logic                         m1_v_q, m2_v_q;
  logic [frsn_pkg::PROD_W-1:0]  m1_prod_q;
  frsn_pkg::frsn_side_t         m1_side_q, m2_side_q, m2_side_d;
  logic [IDX_W-1:0]             m2_rem_q, m2_den_q;
  logic [frsn_pkg::SIN_T_W-1:0] m2_low_q;
  logic [IDX_W:0]               m1_hi;

  always_comb begin
    m1_hi = m1_prod_q[frsn_pkg::PROD_W-1:frsn_pkg::SIN_T_W];
    m2_side_d = m1_side_q;
    m2_side_d.tir = m1_side_q.tir || (m1_hi >= {1'b0, m1_side_q.eta_t});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
    end else if (en) begin
      m1_v_q <= si_v;
      m2_v_q <= m1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_prod_q <= sin_i * si_side.eta_i;
      m1_side_q <= si_side;
      m2_side_q <= m2_side_d;
      m2_rem_q  <= m1_hi[IDX_W-1:0];
      m2_low_q  <= m1_prod_q[frsn_pkg::SIN_T_W-1:0];
      m2_den_q  <= (m1_side_q.eta_t == '0) ? IDX_W'(1) : m1_side_q.eta_t;
    end
  end

  // sin_t
  logic                         st_v;
  logic [frsn_pkg::SIN_T_W-1:0] sin_t;
  frsn_pkg::frsn_side_t         st_side;

  frsn_div #(.DEN_W(IDX_W), .Q_W(frsn_pkg::SIN_T_W),
             .side_t(frsn_pkg::frsn_side_t)) u_div_sin (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(m2_v_q), .rem_i(m2_rem_q), .low_i(m2_low_q), .den_i(m2_den_q),
    .side_i(m2_side_q),
    .valid_o(st_v), .quo_o(sin_t), .side_o(st_side)
  );

  // 1 - sin_t^2
  logic                         m3_v_q, m4_v_q;
  logic [2*frsn_pkg::SIN_T_W-1:0] m3_sq_q;
  logic [frsn_pkg::RAD_W-1:0]   m4_rad_q;
  frsn_pkg::frsn_side_t         m3_side_q, m4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m3_v_q <= 1'b0;
      m4_v_q <= 1'b0;
    end else if (en) begin
      m3_v_q <= st_v;
      m4_v_q <= m3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m3_sq_q   <= sin_t * sin_t;
      m3_side_q <= st_side;
      m4_rad_q  <= frsn_pkg::ONE_Q60 - {2'b00, m3_sq_q};
      m4_side_q <= m3_side_q;
    end
  end

  // cos_t
  logic                 ct_v;
  logic [C_W-1:0]       cos_t;
  frsn_pkg::frsn_side_t ct_side;

  frsn_sqrt #(.IN_W(frsn_pkg::RAD_W), .side_t(frsn_pkg::frsn_side_t)) u_sqrt_cos (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(m4_v_q), .rad_i(m4_rad_q), .side_i(m4_side_q),
    .valid_o(ct_v), .root_o(cos_t), .side_o(ct_side)
  );

  // amplitude ratio terms
  logic                        m5_v_q, m6_v_q;
  logic [frsn_pkg::PROD_W-1:0] a1_q, b1_q, a2_q, b2_q;
  frsn_pkg::frsn_side_t        m5_side_q, m6_side_q, m6_side_d;
  logic [frsn_pkg::DEN_W-1:0]  den_s, den_p, rs_rem_q, rp_rem_q, rs_den_q, rp_den_q;
  logic [frsn_pkg::PROD_W-1:0] num_s, num_p;
  logic [frsn_pkg::RAT_W-1:0]  rs_low_q, rp_low_q;
  logic                        zp_d, m6_zp_q;

  always_comb begin
    den_s = {1'b0, a1_q} + {1'b0, b1_q};
    den_p = {1'b0, a2_q} + {1'b0, b2_q};
    num_s = (a1_q > b1_q) ? a1_q - b1_q : b1_q - a1_q;
    num_p = (a2_q > b2_q) ? a2_q - b2_q : b2_q - a2_q;
    m6_side_d = m5_side_q;
    m6_side_d.zs = (den_s == '0);
    zp_d = (den_p == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m5_v_q <= 1'b0;
      m6_v_q <= 1'b0;
    end else if (en) begin
      m5_v_q <= ct_v;
      m6_v_q <= m5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q      <= ct_side.eta_t * ct_side.c;
      b1_q      <= ct_side.eta_i * cos_t;
      a2_q      <= ct_side.eta_i * ct_side.c;
      b2_q      <= ct_side.eta_t * cos_t;
      m5_side_q <= ct_side;
      m6_side_q <= m6_side_d;
      m6_zp_q   <= zp_d;
      rs_rem_q  <= {2'b00, num_s[frsn_pkg::PROD_W-1:1]};
      rp_rem_q  <= {2'b00, num_p[frsn_pkg::PROD_W-1:1]};
      rs_low_q  <= {num_s[0], {frsn_pkg::RATIO_BITS{1'b0}}};
      rp_low_q  <= {num_p[0], {frsn_pkg::RATIO_BITS{1'b0}}};
      rs_den_q  <= (den_s == '0) ? frsn_pkg::DEN_W'(1) : den_s;
      rp_den_q  <= (den_p == '0) ? frsn_pkg::DEN_W'(1) : den_p;
    end
  end

  // Rs and Rp
  logic                       qs_v, qp_v, qp_z;
  logic [frsn_pkg::RAT_W-1:0] qs, qp;
  frsn_pkg::frsn_side_t       qs_side;

  frsn_div #(.DEN_W(frsn_pkg::DEN_W), .Q_W(frsn_pkg::RAT_W),
             .side_t(frsn_pkg::frsn_side_t)) u_div_rs (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(m6_v_q), .rem_i(rs_rem_q), .low_i(rs_low_q), .den_i(rs_den_q),
    .side_i(m6_side_q),
    .valid_o(qs_v), .quo_o(qs), .side_o(qs_side)
  );

  frsn_div #(.DEN_W(frsn_pkg::DEN_W), .Q_W(frsn_pkg::RAT_W), .side_t(logic)) u_div_rp (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(m6_v_q), .rem_i(rp_rem_q), .low_i(rp_low_q), .den_i(rp_den_q),
    .side_i(m6_zp_q),
    .valid_o(qp_v), .quo_o(qp), .side_o(qp_z)
  );

  // squares, mean, rounding, saturation
  logic                          m7_v_q, m8_v_q, m7_tir_q, m8_tir_q;
  logic [2*frsn_pkg::RAT_W-1:0]  sq_s_q, sq_p_q;
  logic [frsn_pkg::RAT_W-1:0]    rs, rp;
  logic [2*frsn_pkg::RAT_W:0]    sum, rnd;
  logic [frsn_pkg::REFL_W-1:0]   refl_d, m8_refl_q;

  always_comb begin
    rs = qs_side.zs ? frsn_pkg::RAT_ONE : qs;
    rp = qp_z ? frsn_pkg::RAT_ONE : qp;
    sum = {1'b0, sq_s_q} + {1'b0, sq_p_q};
    rnd = (sum + (39'd1 << 21)) >> 22;
    if (m7_tir_q || rnd > 39'(frsn_pkg::REFL_ONE)) begin
      refl_d = frsn_pkg::REFL_ONE;
    end else begin
      refl_d = rnd[frsn_pkg::REFL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m7_v_q <= 1'b0;
      m8_v_q <= 1'b0;
    end else if (en) begin
      m7_v_q <= qs_v && qp_v;
      m8_v_q <= m7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_s_q    <= rs * rs;
      sq_p_q    <= rp * rp;
      m7_tir_q  <= qs_side.tir;
      m8_refl_q <= refl_d;
      m8_tir_q  <= m7_tir_q;
    end
  end

  assign pop = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (pop) begin
        out_v_q <= 1'b1;
        sk_v_q  <= 1'b0;
      end
    end else if (!out_v_q || pop) begin
      out_v_q <= m8_v_q;
    end else if (m8_v_q) begin
      sk_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (pop) begin
        out_refl_q <= sk_refl_q;
        out_tir_q  <= sk_tir_q;
      end
    end else if (!out_v_q || pop) begin
      out_refl_q <= m8_refl_q;
      out_tir_q  <= m8_tir_q;
    end else begin
      sk_refl_q <= m8_refl_q;
      sk_tir_q  <= m8_tir_q;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_refl_q;
  assign m_axis_tuser  = out_tir_q;

endmodule

// File: hw/rtl/frsn_chk.sv
// Port-level checker for the Fresnel reflectance unit, bound to the top.
// Depends on frsn_pkg and fresnel_reflectance_unit_defines.svh.
`include "fresnel_reflectance_unit_defines.svh"

module frsn_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [frsn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser
);

  `FRSN_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output request changed while stalled")
  `FRSN_ASSERT_IMP(a_tir_full, m_axis_tvalid && m_axis_tuser, m_axis_tdata == frsn_pkg::REFL_ONE, "TIR result not 1.0")
  `FRSN_ASSERT_IMP(a_refl_range, m_axis_tvalid, m_axis_tdata <= frsn_pkg::REFL_ONE, "reflectance above 1.0")
  `FRSN_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid && !$past(m_axis_tready), "input stalled with output free")

endmodule

bind fresnel_reflectance_unit frsn_chk u_frsn_chk (.*);

// File: dv/fresnel_reflectance_chk.sv
// Checker for the Fresnel reflectance unit: watches both streams, predicts
// each reflectance from the accepted request and compares in order.
// Depends on frsn_pkg for the port widths.
module fresnel_reflectance_chk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [frsn_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [frsn_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                              m_axis_tuser,
  output int                                fail_cnt,
  output int                                pending_cnt,
  output int                                result_cnt,
  output int                                tir_cnt
);

  typedef struct packed {
    logic [frsn_pkg::REFL_W-1:0] refl;
    logic                        tir;
  } refl_t;

  refl_t refl_q[$];

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] amp_ratio(logic [63:0] a, logic [63:0] b);
    logic [63:0] den;
    logic [63:0] num;
    den = a + b;
    num = (a > b) ? a - b : b - a;
    if (den == 0) return 64'd1 << frsn_pkg::RATIO_BITS;
    return (num << frsn_pkg::RATIO_BITS) / den;
  endfunction

  function automatic refl_t fresnel(logic [frsn_pkg::IN_DATA_W-1:0] d);
    logic signed [63:0] dot;
    logic [63:0] mag, c, sin_i, sin_t, cos_t, eta_i, eta_t, rs, rp, sum;
    refl_t r;
    dot = $signed(d[15:0]) * $signed(d[63:48]) + $signed(d[31:16]) * $signed(d[79:64])
        + $signed(d[47:32]) * $signed(d[95:80]);
    mag = dot < 0 ? -dot : dot;
    if (mag > (64'd1 << 28)) mag = 64'd1 << 28;
    c = mag << 2;
    if (dot > 0) begin
      eta_i = 64'(d[109:96]);
      eta_t = 64'd4096;
    end else begin
      eta_i = 64'd4096;
      eta_t = 64'(d[109:96]);
    end
    r.refl = frsn_pkg::REFL_ONE;
    r.tir  = 1'b1;
    if (eta_t == 0) return r;
    sin_i = isqrt((64'd1 << 60) - c * c);
    sin_t = (sin_i * eta_i) / eta_t;
    if (sin_t >= (64'd1 << 30)) return r;
    cos_t = isqrt((64'd1 << 60) - sin_t * sin_t);
    rs = amp_ratio(eta_t * c, eta_i * cos_t);
    rp = amp_ratio(eta_i * c, eta_t * cos_t);
    sum = (rs * rs + rp * rp + (64'd1 << 21)) >> 22;
    if (sum > 64'd32768) sum = 64'd32768;
    r.refl = sum[15:0];
    r.tir  = 1'b0;
    return r;
  endfunction

  assign pending_cnt = refl_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    refl_t exp_r;
    bit    bad;
    if (!rst_ni) begin
      fail_cnt   <= 0;
      result_cnt <= 0;
      tir_cnt    <= 0;
      refl_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) refl_q.push_back(fresnel(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        result_cnt <= result_cnt + 1;
        tir_cnt    <= tir_cnt + m_axis_tuser;
        bad = 1'b0;
        if (refl_q.size() == 0) begin
          $error("unexpected result: reflectance %0d", m_axis_tdata);
          bad = 1'b1;
        end else begin
          exp_r = refl_q.pop_front();
          if (exp_r.refl !== m_axis_tdata) begin
            $error("reflectance: expected %0d, got %0d", exp_r.refl, m_axis_tdata);
            bad = 1'b1;
          end
          if (exp_r.tir !== m_axis_tuser) begin
            $error("total_internal: expected %0b, got %0b", exp_r.tir, m_axis_tuser);
            bad = 1'b1;
          end
        end
        if (bad) fail_cnt <= fail_cnt + 1;
      end
    end
  end
endmodule

// File: dv/fresnel_reflectance_unit_tb.sv
// Testbench top for the Fresnel reflectance unit: drives surface hits with
// random gaps and back-pressure and reports the verdict from the checker.
// Depends on frsn_pkg, fresnel_reflectance_unit and fresnel_reflectance_chk.
module fresnel_reflectance_unit_tb;

  localparam int LATENCY = 124;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [frsn_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [frsn_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  int fail_cnt, pending_cnt, result_cnt, tir_cnt;
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 1'b0;
  int sent = 0;

  fresnel_reflectance_unit u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  fresnel_reflectance_chk u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_cnt, .pending_cnt, .result_cnt, .tir_cnt
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_hit(logic [15:0] dx, dy, dz, nx, ny, nz, logic [13:0] idx);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {2'b00, idx, nz, ny, nx, dz, dy, dx};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [15:0] rnd_comp();
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  task automatic send_unit_hit(bit leave);
    int ax, ay, s;
    logic [15:0] d, n;
    ax = $urandom_range(16384);
    ay = 16384 - ax;
    s  = $urandom_range(1) ? 1 : -1;
    d  = 16'(s * ax);
    n  = leave ? d : -d;
    send_hit(d, 16'(ay), 16'd0, n, 16'(ay), 16'd0, 14'($urandom_range(16383, 1024)));
  endtask

  task automatic run_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      if (k < 3) send_unit_hit(1'b0);
      else if (k < 6) send_unit_hit(1'b1);
      else if (k < 9)
        send_hit(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(),
                 14'($urandom_range(16383, 1024)));
      else
        send_hit(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), 14'($urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: normal incidence both ways, grazing, extremes, zero index, TIR
    send_hit(16'h0000, 16'd0, 16'sd16384, 16'd0, 16'd0, -16'sd16384, 14'd6144);
    send_hit(16'h0000, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'sd16384, 14'd6144);
    send_hit(16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 14'd6144);
    send_hit(16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 14'd0);
    send_hit(16'sd11585, 16'sd11585, 16'd0, 16'sd16384, 16'd0, 16'd0, 14'd6144);
    send_hit(16'sd11585, 16'sd11585, 16'd0, -16'sd16384, 16'd0, 16'd0, 14'd6144);
    send_hit(16'sd11585, 16'sd11585, 16'd0, -16'sd16384, 16'd0, 16'd0, 14'd0);
    send_hit(16'sd11585, 16'sd11585, 16'd0, -16'sd16384, 16'd0, 16'd0, 14'd16383);
    send_hit(16'sd11585, 16'sd11585, 16'd0, -16'sd16384, 16'd0, 16'd0, 14'd1024);
    send_hit(16'sd11585, 16'sd11585, 16'd0, 16'sd16384, 16'd0, 16'd0, 14'd1024);
    send_hit(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 14'd4096);
    send_hit(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 14'h3FFF);
    send_hit(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 14'd4096);
    send_hit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 14'h3FFF);
    send_hit(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 14'd4096);
    send_hit(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 14'd0);

    send_idle = 28; recv_idle = 82;
    run_random(160);
    send_idle = 82; recv_idle = 28;
    run_random(160);
    send_idle = 0; recv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      run_random(180);
    join
    s_axis_tvalid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Sent %0d surface hits; %0d results checked, %0d with total internal reflection.",
             sent, result_cnt, tir_cnt);
    if (fail_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
